// ===== hdl/lbcf_pkg.sv =====
// Shared types and constants for the label box collision filter.
// No dependencies; the top level and the geometry unit refer to it by scoped names.
package lbcf_pkg;

  localparam int COORD_W = 24;
  localparam int AXIS_W  = 20;
  localparam int LEN_W   = 8;
  localparam int FONT_W  = 8;
  localparam int SCR_W   = 14;
  localparam int CFG_IDX_W = 2;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = 14'd1024;
  localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 14'd768;

  localparam logic [FONT_W-1:0] MIN_FONT        = 8'd8;
  localparam logic [LEN_W-1:0]  COMPACT_MAX_LEN = 8'd4;

  // shared multiplier operand widths
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 27;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // ceil(2^33 / 100): x / 100 for x < 2^26 as (x * RECIP_100) >> 33
  localparam logic [MUL_B_W-1:0] RECIP_100 = 27'd85899346;
  localparam int RECIP_SHIFT = 33;
  localparam int WIDTH_W = 20;

  // Q4 offsets and padding
  localparam logic signed [COORD_W-1:0] COMPACT_DY  = 24'sd32;
  localparam logic signed [COORD_W-1:0] COMPACT_PAD = 24'sd16;
  localparam logic signed [COORD_W-1:0] NORMAL_DX   = 24'sd96;
  localparam logic signed [COORD_W-1:0] NORMAL_DY   = 24'sd96;
  localparam logic signed [COORD_W-1:0] NORMAL_PADX = 24'sd64;
  localparam logic signed [COORD_W-1:0] NORMAL_PADY = 24'sd32;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
  } box_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] anchor_x;
    logic signed [AXIS_W-1:0] anchor_y;
    logic [LEN_W-1:0]         text_len;
    logic [FONT_W-1:0]        height;
    logic                     compact;
  } item_t;

  typedef struct packed {
    logic                      valid;
    logic                      vis;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    box_t                      box;
  } geom_res_t;

endpackage

// ===== hdl/label_box_collision_filter_top.sv =====
// Channel   | Ports                                              | Handshake
// label in  | new_frame anchor_x anchor_y text_len font_px       | start & !busy
//           | compact_class                                      |
// result    | accepted on_screen store_full origin_x/y box_*     | done, one cycle
// config    | cfg_index cfg_data                                 | cfg_valid & cfg_ready
//
// A label with text goes through the geometry unit (one shared multiplier); if it is
// on screen, one compare per stored box through the box RAM read port follows, up to
// the first hit, and then a commit step.
// A label with no text gives no result and leaves the block idle.
// Reset clears the box count and loads the default viewport; RAM is not cleared.
// The result side cannot stall; config is always ready.
// Uses lbcf_pkg, lbcf_geom, lbcf_ram.
module label_box_collision_filter_top #(
  parameter int MAX_BOXES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 new_frame,
  input  logic signed [lbcf_pkg::AXIS_W-1:0]   anchor_x,
  input  logic signed [lbcf_pkg::AXIS_W-1:0]   anchor_y,
  input  logic [lbcf_pkg::LEN_W-1:0]           text_len,
  input  logic [lbcf_pkg::FONT_W-1:0]          font_px,
  input  logic                                 compact_class,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lbcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lbcf_pkg::SCR_W-1:0]           cfg_data,
  output logic                                 done,
  output logic                                 accepted,
  output logic                                 on_screen,
  output logic                                 store_full,
  output logic signed [lbcf_pkg::COORD_W-1:0]  origin_x,
  output logic signed [lbcf_pkg::COORD_W-1:0]  origin_y,
  output logic signed [lbcf_pkg::COORD_W-1:0]  box_left,
  output logic signed [lbcf_pkg::COORD_W-1:0]  box_top,
  output logic signed [lbcf_pkg::COORD_W-1:0]  box_right,
  output logic signed [lbcf_pkg::COORD_W-1:0]  box_bottom
);

  localparam int ADDR_W = $clog2(MAX_BOXES);
  localparam int CNT_W  = $clog2(MAX_BOXES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BOXES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_GEOM   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]                  state;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            idx;
  logic                        rd_vld;
  logic                        blocked;
  logic [lbcf_pkg::SCR_W-1:0]  screen_width;
  logic [lbcf_pkg::SCR_W-1:0]  screen_height;
  logic                        go;
  logic                        hit;
  logic                        room;
  logic                        acc;
  logic                        full;
  lbcf_pkg::item_t             item;
  lbcf_pkg::geom_res_t         geo;
  lbcf_pkg::box_t              sbox;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign go        = start && !busy && (text_len != '0);

  assign item.anchor_x = anchor_x;
  assign item.anchor_y = anchor_y;
  assign item.text_len = text_len;
  assign item.height   = (font_px < lbcf_pkg::MIN_FONT) ? lbcf_pkg::MIN_FONT : font_px;
  assign item.compact  = compact_class && (text_len <= lbcf_pkg::COMPACT_MAX_LEN);

  lbcf_geom u_geom (
    .clk           (clk),
    .rst           (rst),
    .go            (go),
    .item          (item),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .res           (geo)
  );

  lbcf_ram #(
    .WIDTH ($bits(lbcf_pkg::box_t)),
    .DEPTH (MAX_BOXES)
  ) u_ram (
    .clk   (clk),
    .we    (state == ST_FINISH && acc),
    .waddr (count[ADDR_W-1:0]),
    .wdata (geo.box),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (sbox)
  );

  // strict overlap against the stored box read last cycle
  assign hit = rd_vld &&
               (geo.box.left < sbox.right) && (geo.box.right > sbox.left) &&
               (geo.box.top < sbox.bottom) && (geo.box.bottom > sbox.top);

  assign room = (count < MAX_CNT);
  assign acc  = geo.vis && !blocked && room;
  assign full = geo.vis && !blocked && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= lbcf_pkg::SCREEN_WIDTH_RST;
      screen_height <= lbcf_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lbcf_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        lbcf_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      idx    <= '0;
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= (state == ST_SCAN) && (idx < count) && !hit;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (new_frame) begin
              count <= '0;
            end
            blocked <= 1'b0;
            idx     <= '0;
            if (text_len != '0) begin
              state <= ST_GEOM;
            end
          end
        end
        ST_GEOM: begin
          if (geo.valid) begin
            state <= geo.vis ? ST_SCAN : ST_FINISH;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            blocked <= 1'b1;
            state   <= ST_FINISH;
          end else if (idx == count && !rd_vld) begin
            state <= ST_FINISH;
          end else if (idx < count) begin
            idx <= idx + 1'b1;
          end
        end
        ST_FINISH: begin
          if (acc) begin
            count <= count + 1'b1;
          end
          accepted   <= acc;
          on_screen  <= geo.vis;
          store_full <= full;
          origin_x   <= geo.origin_x;
          origin_y   <= geo.origin_y;
          box_left   <= geo.box.left;
          box_top    <= geo.box.top;
          box_right  <= geo.box.right;
          box_bottom <= geo.box.bottom;
          done       <= 1'b1;
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/lbcf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lbcf_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/lbcf_geom.sv =====
// Box geometry unit: text width, origin, padded box and viewport test.
// One shared multiplier under a short step sequence. Uses lbcf_pkg.
module lbcf_geom (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  lbcf_pkg::item_t               item,
  input  logic [lbcf_pkg::SCR_W-1:0]    screen_width,
  input  logic [lbcf_pkg::SCR_W-1:0]    screen_height,
  output lbcf_pkg::geom_res_t           res
);

  localparam logic [2:0] G_IDLE   = 3'd0;
  localparam logic [2:0] G_MUL    = 3'd1;
  localparam logic [2:0] G_SCALE  = 3'd2;
  localparam logic [2:0] G_DIVW   = 3'd3;
  localparam logic [2:0] G_DIVH   = 3'd4;
  localparam logic [2:0] G_ORIGIN = 3'd5;
  localparam logic [2:0] G_BOX    = 3'd6;
  localparam logic [2:0] G_VIS    = 3'd7;

  logic [2:0]                      step;
  lbcf_pkg::item_t                 it;
  logic [15:0]                     lh;
  logic [lbcf_pkg::MUL_A_W-1:0]    num_w;
  logic [lbcf_pkg::MUL_A_W-2:0]    num_h;
  logic [lbcf_pkg::WIDTH_W-1:0]    w;
  logic [lbcf_pkg::WIDTH_W-1:0]    hw;
  logic [lbcf_pkg::MUL_A_W-1:0]    mul_a;
  logic [lbcf_pkg::MUL_B_W-1:0]    mul_b;
  logic [lbcf_pkg::MUL_P_W-1:0]    prod;
  logic [lbcf_pkg::WIDTH_W-1:0]    quot;
  logic signed [lbcf_pkg::COORD_W-1:0] ax, ay, ox, oy, px, py;
  logic signed [lbcf_pkg::COORD_W-1:0] scr_x, scr_y;

  always_comb begin
    case (step)
      G_MUL: begin
        mul_a = {{(lbcf_pkg::MUL_A_W-lbcf_pkg::LEN_W){1'b0}}, it.text_len};
        mul_b = {{(lbcf_pkg::MUL_B_W-lbcf_pkg::FONT_W){1'b0}}, it.height};
      end
      G_DIVW: begin
        mul_a = num_w;
        mul_b = lbcf_pkg::RECIP_100;
      end
      G_DIVH: begin
        mul_a = {1'b0, num_h};
        mul_b = lbcf_pkg::RECIP_100;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign quot = prod[lbcf_pkg::RECIP_SHIFT +: lbcf_pkg::WIDTH_W];

  assign ax = lbcf_pkg::COORD_W'(it.anchor_x);
  assign ay = lbcf_pkg::COORD_W'(it.anchor_y);
  assign px = it.compact ? lbcf_pkg::COMPACT_PAD : lbcf_pkg::NORMAL_PADX;
  assign py = it.compact ? lbcf_pkg::COMPACT_PAD : lbcf_pkg::NORMAL_PADY;
  assign scr_x = $signed({6'b0, screen_width, 4'b0});
  assign scr_y = $signed({6'b0, screen_height, 4'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= G_IDLE;
      res.valid <= 1'b0;
    end else begin
      res.valid <= 1'b0;
      case (step)
        G_IDLE: begin
          if (go) begin
            it   <= item;
            step <= G_MUL;
          end
        end
        G_MUL: begin
          lh   <= prod[15:0];
          step <= G_SCALE;
        end
        G_SCALE: begin
          // round half up: (lh*992 + 50) / 100 and (lh*496 + 50) / 100
          num_w <= ({10'b0, lh} << 10) - ({10'b0, lh} << 5) + 26'd50;
          num_h <= ({9'b0, lh} << 9) - ({9'b0, lh} << 4) + 25'd50;
          step  <= G_DIVW;
        end
        G_DIVW: begin
          w    <= quot;
          step <= G_DIVH;
        end
        G_DIVH: begin
          hw   <= quot;
          step <= G_ORIGIN;
        end
        G_ORIGIN: begin
          if (it.compact) begin
            ox <= ax - $signed({4'b0, hw});
            oy <= ay - lbcf_pkg::COMPACT_DY;
          end else begin
            ox <= ax + lbcf_pkg::NORMAL_DX;
            oy <= ay - lbcf_pkg::NORMAL_DY;
          end
          step <= G_BOX;
        end
        G_BOX: begin
          res.origin_x   <= ox;
          res.origin_y   <= oy;
          res.box.left   <= ox - px;
          res.box.top    <= oy - $signed({12'b0, it.height, 4'b0}) - py;
          res.box.right  <= ox + $signed({4'b0, w}) + px;
          res.box.bottom <= oy + py;
          step           <= G_VIS;
        end
        G_VIS: begin
          res.vis <= !res.box.right[lbcf_pkg::COORD_W-1] &&
                     !res.box.bottom[lbcf_pkg::COORD_W-1] &&
                     (res.box.left <= scr_x) && (res.box.top <= scr_y);
          res.valid <= 1'b1;
          step      <= G_IDLE;
        end
        default: step <= G_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/lbcf_check.sv =====
// Port-level checks for the label box collision filter, bound to the top level.
// Depends only on the top level's ports.
module lbcf_check (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [7:0] text_len,
  input logic       done,
  input logic       accepted,
  input logic       on_screen,
  input logic       store_full
);

  // a label with text that is taken while idle makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (text_len != 8'd0) |=> busy)
    else $error("label with text did not make the block busy");

  // a result only follows a cycle of work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without prior work");

  a_accept_visible: assert property (@(posedge clk) disable iff (rst)
    done && accepted |-> on_screen && !store_full)
    else $error("accepted label off screen or flagged full");

  a_full_visible: assert property (@(posedge clk) disable iff (rst)
    done && store_full |-> on_screen && !accepted)
    else $error("store full flag on a label that was off screen or placed");

endmodule

bind label_box_collision_filter_top lbcf_check u_lbcf_check (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .text_len   (text_len),
  .done       (done),
  .accepted   (accepted),
  .on_screen  (on_screen),
  .store_full (store_full)
);
